@@ rtl/udff_pkg.sv @@
// Package: shared constants, types and helpers of the decimal field formatter.
package udff_pkg;

	localparam int MAX_FIELD   = 64;
	localparam int MAX_DIGITS  = 10;
	localparam int VALUE_W     = 32;
	localparam int LEN_W       = 7;
	localparam int DIG_W       = 4;
	localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
	localparam int NDIG_W      = $clog2(MAX_DIGITS + 1);
	localparam int CHAR_W      = 8;

	localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
	localparam int                 RECIP_SHFT = 35;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

	typedef enum logic [1:0] {
		CV_IDLE,
		CV_MUL,
		CV_SUB
	} conv_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_LEN,
		ST_PAD,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic              busy;
		logic [NDIG_W-1:0] ndig;
	} conv_status_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
		logic [CHAR_W-1:0] c;
		case (d)
			4'd0: c = 8'h30;
			4'd1: c = 8'h31;
			4'd2: c = 8'h32;
			4'd3: c = 8'h33;
			4'd4: c = 8'h34;
			4'd5: c = 8'h35;
			4'd6: c = 8'h36;
			4'd7: c = 8'h37;
			4'd8: c = 8'h38;
			4'd9: c = 8'h39;
			default: c = CH_ZERO;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/unsigned_decimal_field_formatter_core.sv @@
// Top level of the unsigned decimal field formatter.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_ready  | number, field_width, precision, left_justify, zero_pad
//  out     | out_valid / out_ready| character, last_char
//
// An item's first character waits for the reciprocal multiplier, which peels one
// digit per pass through its multiply and subtract states; the digit count is 1..10.
// Characters then leave one a cycle while out_ready is high; a stall holds the sequencer.
// in_ready is high only while no item is being converted or emitted.
// Reset clears the sequencers and the output valid; an empty field gives no item.
module unsigned_decimal_field_formatter_core #(
	parameter int MAX_FIELD = udff_pkg::MAX_FIELD
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [udff_pkg::VALUE_W-1:0]       number,
	input  logic [udff_pkg::LEN_W-1:0]         field_width,
	input  logic signed [7:0]                  precision,
	input  logic                               left_justify,
	input  logic                               zero_pad,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [udff_pkg::CHAR_W-1:0]        character,
	output logic                               last_char
);

	logic                              conv_start;
	logic [udff_pkg::DIG_IDX_W-1:0]    rd_idx;
	logic [udff_pkg::DIG_W-1:0]        rd_digit;
	udff_pkg::conv_status_t            conv_status;

	udff_conv u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (conv_start),
		.value    (number),
		.rd_idx   (rd_idx),
		.rd_digit (rd_digit),
		.status   (conv_status)
	);

	udff_ctrl #(
		.MAX_FIELD (MAX_FIELD)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.number       (number),
		.field_width  (field_width),
		.precision    (precision),
		.left_justify (left_justify),
		.zero_pad     (zero_pad),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.character    (character),
		.last_char    (last_char),
		.conv_start   (conv_start),
		.rd_idx       (rd_idx),
		.rd_digit     (rd_digit),
		.conv_status  (conv_status)
	);

endmodule

@@ rtl/udff_conv.sv @@
// Iterative binary to decimal converter: one reciprocal multiply per digit.
module udff_conv (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [udff_pkg::VALUE_W-1:0]       value,
	input  logic [udff_pkg::DIG_IDX_W-1:0]     rd_idx,
	output logic [udff_pkg::DIG_W-1:0]         rd_digit,
	output udff_pkg::conv_status_t             status
);

	udff_pkg::conv_state_t                state_q, state_d;
	logic [udff_pkg::VALUE_W-1:0]         v_q;
	logic [2*udff_pkg::VALUE_W-1:0]       prod_q;
	logic [udff_pkg::NDIG_W-1:0]          n_q;
	logic [udff_pkg::DIG_W-1:0]           digit_q [udff_pkg::MAX_DIGITS];
	logic [2*udff_pkg::VALUE_W-udff_pkg::RECIP_SHFT-1:0] quo;
	logic [udff_pkg::DIG_W-1:0]           rem;
	logic                                 last_dig;

	assign quo = prod_q[2*udff_pkg::VALUE_W-1:udff_pkg::RECIP_SHFT];
	assign rem = v_q[udff_pkg::DIG_W-1:0] - {quo[0], 3'b000} - {quo[2:0], 1'b0};
	assign last_dig = (quo == '0) ||
		(n_q == udff_pkg::NDIG_W'(udff_pkg::MAX_DIGITS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			udff_pkg::CV_IDLE: if (start) state_d = udff_pkg::CV_MUL;
			udff_pkg::CV_MUL:  state_d = udff_pkg::CV_SUB;
			udff_pkg::CV_SUB:  state_d = last_dig ? udff_pkg::CV_IDLE : udff_pkg::CV_MUL;
			default:           state_d = udff_pkg::CV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= udff_pkg::CV_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == udff_pkg::CV_IDLE && start)
				n_q <= '0;
			else if (state_q == udff_pkg::CV_SUB)
				n_q <= n_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == udff_pkg::CV_IDLE && start)
			v_q <= value;
		else if (state_q == udff_pkg::CV_SUB)
			v_q <= udff_pkg::VALUE_W'(quo);
		if (state_q == udff_pkg::CV_MUL)
			prod_q <= (2*udff_pkg::VALUE_W)'(v_q) * (2*udff_pkg::VALUE_W)'(udff_pkg::RECIP_TEN);
		if (state_q == udff_pkg::CV_SUB)
			digit_q[n_q[udff_pkg::DIG_IDX_W-1:0]] <= rem;
	end

	assign rd_digit = (rd_idx < udff_pkg::DIG_IDX_W'(udff_pkg::MAX_DIGITS)) ?
		digit_q[rd_idx] : '0;

	assign status.busy = (state_q != udff_pkg::CV_IDLE);
	assign status.ndig = n_q;

endmodule

@@ rtl/udff_ctrl.sv @@
// Field sequencer: latches options, sizes field, one char a cycle unless stalled.
module udff_ctrl #(
	parameter int MAX_FIELD = udff_pkg::MAX_FIELD
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [udff_pkg::VALUE_W-1:0]       number,
	input  logic [udff_pkg::LEN_W-1:0]         field_width,
	input  logic signed [7:0]                  precision,
	input  logic                               left_justify,
	input  logic                               zero_pad,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [udff_pkg::CHAR_W-1:0]        character,
	output logic                               last_char,
	output logic                               conv_start,
	output logic [udff_pkg::DIG_IDX_W-1:0]     rd_idx,
	input  logic [udff_pkg::DIG_W-1:0]         rd_digit,
	input  udff_pkg::conv_status_t             conv_status
);

	localparam logic [udff_pkg::LEN_W-1:0] FIELD_MAX = udff_pkg::LEN_W'(MAX_FIELD);

	udff_pkg::ctrl_state_t           state_q, state_d;
	logic [udff_pkg::LEN_W-1:0]      width_q, prec_q, ndig_q, body_q, pad_q, off_q, r_q;
	logic                            has_prec_q, left_q, zero_q, vzero_q;
	logic [udff_pkg::CHAR_W-1:0]     pad_ch_q;
	logic [udff_pkg::CHAR_W-1:0]     char_q;
	logic                            last_q, ovalid_q;
	logic                            accept, emit_go, blank;
	logic [udff_pkg::LEN_W-1:0]      ndig_eff, pad_len, total, s;
	logic [udff_pkg::LEN_W-1:0]      prec_in;
	logic                            is_pad;
	logic [udff_pkg::CHAR_W-1:0]     next_char;

	assign in_ready   = (state_q == udff_pkg::ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign conv_start = accept;
	assign emit_go    = (state_q == udff_pkg::ST_EMIT) && (!ovalid_q || out_ready);

	assign prec_in  = (precision[6:0] > FIELD_MAX) ? FIELD_MAX : precision[6:0];
	assign blank    = has_prec_q && (prec_q == '0) && vzero_q;
	assign ndig_eff = blank ? '0 : udff_pkg::LEN_W'(conv_status.ndig);
	assign pad_len  = (width_q > body_q) ? width_q - body_q : '0;
	assign total    = pad_len + body_q;

	assign s      = r_q - off_q;
	assign is_pad = left_q ? (r_q < pad_q) : (r_q >= body_q);
	assign rd_idx = s[udff_pkg::DIG_IDX_W-1:0];

	always_comb begin
		if (is_pad)
			next_char = pad_ch_q;
		else if (s >= ndig_q)
			next_char = udff_pkg::CH_ZERO;
		else
			next_char = udff_pkg::digit_char(rd_digit);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			udff_pkg::ST_IDLE: if (accept) state_d = udff_pkg::ST_CONV;
			udff_pkg::ST_CONV: if (!conv_status.busy) state_d = udff_pkg::ST_LEN;
			udff_pkg::ST_LEN:  state_d = udff_pkg::ST_PAD;
			udff_pkg::ST_PAD:  state_d = (total == '0) ? udff_pkg::ST_IDLE : udff_pkg::ST_EMIT;
			udff_pkg::ST_EMIT: if (emit_go && r_q == '0) state_d = udff_pkg::ST_IDLE;
			default:           state_d = udff_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= udff_pkg::ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_go)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			width_q    <= (field_width > FIELD_MAX) ? FIELD_MAX : field_width;
			has_prec_q <= !precision[7];
			prec_q     <= precision[7] ? '0 : prec_in;
			left_q     <= left_justify;
			zero_q     <= zero_pad;
			vzero_q    <= (number == '0);
		end
		if (state_q == udff_pkg::ST_LEN) begin
			ndig_q   <= ndig_eff;
			body_q   <= ((has_prec_q && prec_q > ndig_eff) ? prec_q : ndig_eff);
			pad_ch_q <= (zero_q && !left_q && !has_prec_q) ? udff_pkg::CH_ZERO
			                                                : udff_pkg::CH_SPACE;
		end
		if (state_q == udff_pkg::ST_PAD) begin
			pad_q <= pad_len;
			off_q <= left_q ? pad_len : '0;
			r_q   <= total - 1'b1;
		end else if (emit_go) begin
			r_q <= r_q - 1'b1;
		end
		if (emit_go) begin
			char_q <= next_char;
			last_q <= (r_q == '0);
		end
	end

	assign out_valid = ovalid_q;
	assign character = char_q;
	assign last_char = last_q;

endmodule
